### rtl/exlex_pkg.sv
// Shared types, constants and helper functions of the expression lexer.
`default_nettype none

package exlex_pkg;

    // Offsets wrap modulo the text length; lengths saturate at it.
    localparam int MAX_TEXT_LEN = 4096;
    localparam int OFF_W        = $clog2(MAX_TEXT_LEN);
    localparam int LEN_W        = $clog2(MAX_TEXT_LEN + 1);
    localparam int NUM_W        = 31;
    localparam int CHAR_W       = 8;
    localparam int KIND_W       = 3;

    localparam logic [NUM_W-1:0] NUM_MAX = '1;

    // One byte can close up to three tokens.
    localparam int TOK_SLOTS  = 3;
    localparam int SLOT_CNT_W = $clog2(TOK_SLOTS + 1);

    // Default depth of the token queue (a power of two, at least 4).
    localparam int FIFO_DEPTH = 8;

    localparam logic [KIND_W-1:0] KIND_RESERVED = 3'd0;
    localparam logic [KIND_W-1:0] KIND_IDENT    = 3'd1;
    localparam logic [KIND_W-1:0] KIND_NUMBER   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_EOF      = 3'd3;
    localparam logic [KIND_W-1:0] KIND_ERROR    = 3'd4;

    localparam logic [CHAR_W-1:0] CH_EQ     = 8'h3D;
    localparam logic [CHAR_W-1:0] CH_BANG   = 8'h21;
    localparam logic [CHAR_W-1:0] CH_LT     = 8'h3C;
    localparam logic [CHAR_W-1:0] CH_GT     = 8'h3E;
    localparam logic [CHAR_W-1:0] CH_PLUS   = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_STAR   = 8'h2A;
    localparam logic [CHAR_W-1:0] CH_SLASH  = 8'h2F;
    localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28;
    localparam logic [CHAR_W-1:0] CH_RPAREN = 8'h29;
    localparam logic [CHAR_W-1:0] CH_SEMI   = 8'h3B;
    localparam logic [CHAR_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [CHAR_W-1:0] CH_TAB    = 8'h09;
    localparam logic [CHAR_W-1:0] CH_CR     = 8'h0D;
    localparam logic [CHAR_W-1:0] CH_LOW_A  = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LOW_Z  = 8'h7A;
    localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE   = 8'h39;

    typedef enum logic [3:0] {
        MODE_IDLE    = 4'b0001,
        MODE_HELD    = 4'b0010,
        MODE_NUMBER  = 4'b0100,
        MODE_DISCARD = 4'b1000
    } lex_mode_t;

    typedef struct packed {
        logic [CHAR_W-1:0] char_in;
        logic              last_char;
    } char_beat_t;

    typedef struct packed {
        logic [KIND_W-1:0] token_kind;
        logic [CHAR_W-1:0] first_char;
        logic [CHAR_W-1:0] second_char;
        logic [NUM_W-1:0]  number_value;
        logic [OFF_W-1:0]  token_start;
        logic [LEN_W-1:0]  token_length;
        logic              final_token;
    } token_beat_t;

    typedef struct packed {
        lex_mode_t         mode;
        logic [CHAR_W-1:0] held_char;
        logic [NUM_W-1:0]  number_accum;
        logic [OFF_W-1:0]  start_offset;
        logic [LEN_W-1:0]  digit_count;
        logic [OFF_W-1:0]  byte_offset;
    } lex_state_t;

    typedef struct packed {
        token_beat_t [TOK_SLOTS-1:0] tok;
        logic [SLOT_CNT_W-1:0]       count;
        lex_state_t                  state;
    } step_result_t;

    function automatic lex_state_t reset_state();
        lex_state_t s;
        s.mode         = MODE_IDLE;
        s.held_char    = '0;
        s.number_accum = '0;
        s.start_offset = '0;
        s.digit_count  = '0;
        s.byte_offset  = '0;
        return s;
    endfunction

    function automatic token_beat_t make_token(
        input logic [KIND_W-1:0] kind,
        input logic [CHAR_W-1:0] c1,
        input logic [CHAR_W-1:0] c2,
        input logic [NUM_W-1:0]  num,
        input logic [OFF_W-1:0]  start,
        input logic [LEN_W-1:0]  len,
        input logic              fin
    );
        token_beat_t t;
        t.token_kind   = kind;
        t.first_char   = c1;
        t.second_char  = c2;
        t.number_value = num;
        t.token_start  = start;
        t.token_length = len;
        t.final_token  = fin;
        return t;
    endfunction

endpackage

`default_nettype wire

### rtl/exlex_step.sv
// Combinational next-state and token logic for one source byte.
`default_nettype none

module exlex_step (
    input  wire exlex_pkg::lex_state_t state,
    input  wire exlex_pkg::char_beat_t beat,
    output exlex_pkg::step_result_t    result
);

    always_comb begin
        logic [exlex_pkg::CHAR_W-1:0]                c;
        logic                                        used;
        logic [exlex_pkg::SLOT_CNT_W-1:0]            n;
        exlex_pkg::lex_state_t                       nx;
        exlex_pkg::token_beat_t [exlex_pkg::TOK_SLOTS-1:0] tok;
        logic [exlex_pkg::NUM_W+3:0]                 wide;
        logic [exlex_pkg::NUM_W+3:0]                 digit;
        logic [exlex_pkg::OFF_W-1:0]                 off_next;

        c     = beat.char_in;
        used  = 1'b0;
        n     = '0;
        nx    = state;
        tok   = '0;
        digit = {{(exlex_pkg::NUM_W){1'b0}}, 4'(c - exlex_pkg::CH_ZERO)};
        wide  = '0;

        if (state.byte_offset == exlex_pkg::OFF_W'(exlex_pkg::MAX_TEXT_LEN - 1)) begin
            off_next = '0;
        end else begin
            off_next = state.byte_offset + 1'b1;
        end

        // Finish whatever the previous bytes left pending.
        case (state.mode)
            exlex_pkg::MODE_DISCARD:
            begin
                used = 1'b1;
            end
            exlex_pkg::MODE_HELD:
            begin
                if (c == exlex_pkg::CH_EQ) begin
                    tok[n] = exlex_pkg::make_token(exlex_pkg::KIND_RESERVED, state.held_char,
                        exlex_pkg::CH_EQ, '0, state.start_offset,
                        exlex_pkg::LEN_W'(2), 1'b0);
                    n       = n + 1'b1;
                    nx.mode = exlex_pkg::MODE_IDLE;
                    used    = 1'b1;
                end else if (state.held_char == exlex_pkg::CH_LT ||
                             state.held_char == exlex_pkg::CH_GT) begin
                    tok[n] = exlex_pkg::make_token(exlex_pkg::KIND_RESERVED, state.held_char,
                        '0, '0, state.start_offset, exlex_pkg::LEN_W'(1), 1'b0);
                    n       = n + 1'b1;
                    nx.mode = exlex_pkg::MODE_IDLE;
                end else begin
                    // A lone '=' or '!' is an error, and this byte goes with it.
                    tok[n] = exlex_pkg::make_token(exlex_pkg::KIND_ERROR, '0, '0, '0,
                        state.start_offset, exlex_pkg::LEN_W'(1), 1'b1);
                    n       = n + 1'b1;
                    nx.mode = exlex_pkg::MODE_DISCARD;
                    used    = 1'b1;
                end
            end
            exlex_pkg::MODE_NUMBER:
            begin
                if (c inside {[exlex_pkg::CH_ZERO:exlex_pkg::CH_NINE]}) begin
                    // accum * 10 + d, saturating at the largest 31-bit value.
                    wide = ({4'd0, state.number_accum} << 3) +
                           ({4'd0, state.number_accum} << 1) + digit;
                    if (wide > {4'd0, exlex_pkg::NUM_MAX}) begin
                        nx.number_accum = exlex_pkg::NUM_MAX;
                    end else begin
                        nx.number_accum = wide[exlex_pkg::NUM_W-1:0];
                    end
                    if (state.digit_count < exlex_pkg::LEN_W'(exlex_pkg::MAX_TEXT_LEN)) begin
                        nx.digit_count = state.digit_count + 1'b1;
                    end
                    used = 1'b1;
                end else begin
                    tok[n] = exlex_pkg::make_token(exlex_pkg::KIND_NUMBER, '0, '0,
                        state.number_accum, state.start_offset, state.digit_count, 1'b0);
                    n       = n + 1'b1;
                    nx.mode = exlex_pkg::MODE_IDLE;
                end
            end
            default:
            begin
                used = 1'b0;
            end
        endcase

        // Classify the byte itself when nothing above consumed it.
        if (!used) begin
            if (c inside {exlex_pkg::CH_SPACE, [exlex_pkg::CH_TAB:exlex_pkg::CH_CR]}) begin
                nx.mode = nx.mode;
            end else if (c inside {exlex_pkg::CH_EQ, exlex_pkg::CH_BANG,
                                   exlex_pkg::CH_LT, exlex_pkg::CH_GT}) begin
                nx.held_char    = c;
                nx.start_offset = state.byte_offset;
                nx.mode         = exlex_pkg::MODE_HELD;
            end else if (c inside {[exlex_pkg::CH_LOW_A:exlex_pkg::CH_LOW_Z]}) begin
                tok[n] = exlex_pkg::make_token(exlex_pkg::KIND_IDENT, c, '0, '0,
                    state.byte_offset, exlex_pkg::LEN_W'(1), 1'b0);
                n = n + 1'b1;
            end else if (c inside {exlex_pkg::CH_PLUS, exlex_pkg::CH_MINUS,
                                   exlex_pkg::CH_STAR, exlex_pkg::CH_SLASH,
                                   exlex_pkg::CH_LPAREN, exlex_pkg::CH_RPAREN,
                                   exlex_pkg::CH_SEMI}) begin
                tok[n] = exlex_pkg::make_token(exlex_pkg::KIND_RESERVED, c, '0, '0,
                    state.byte_offset, exlex_pkg::LEN_W'(1), 1'b0);
                n = n + 1'b1;
            end else if (c inside {[exlex_pkg::CH_ZERO:exlex_pkg::CH_NINE]}) begin
                nx.number_accum = {{(exlex_pkg::NUM_W-4){1'b0}}, digit[3:0]};
                nx.digit_count  = exlex_pkg::LEN_W'(1);
                nx.start_offset = state.byte_offset;
                nx.mode         = exlex_pkg::MODE_NUMBER;
            end else begin
                tok[n] = exlex_pkg::make_token(exlex_pkg::KIND_ERROR, '0, '0, '0,
                    state.byte_offset, exlex_pkg::LEN_W'(1), 1'b1);
                n       = n + 1'b1;
                nx.mode = exlex_pkg::MODE_DISCARD;
            end
        end

        // The final byte flushes the pending token and closes the string.
        if (beat.last_char) begin
            if (nx.mode == exlex_pkg::MODE_HELD) begin
                if (nx.held_char == exlex_pkg::CH_LT || nx.held_char == exlex_pkg::CH_GT) begin
                    tok[n] = exlex_pkg::make_token(exlex_pkg::KIND_RESERVED, nx.held_char,
                        '0, '0, nx.start_offset, exlex_pkg::LEN_W'(1), 1'b0);
                    n       = n + 1'b1;
                    nx.mode = exlex_pkg::MODE_IDLE;
                end else begin
                    tok[n] = exlex_pkg::make_token(exlex_pkg::KIND_ERROR, '0, '0, '0,
                        nx.start_offset, exlex_pkg::LEN_W'(1), 1'b1);
                    n       = n + 1'b1;
                    nx.mode = exlex_pkg::MODE_DISCARD;
                end
            end else if (nx.mode == exlex_pkg::MODE_NUMBER) begin
                tok[n] = exlex_pkg::make_token(exlex_pkg::KIND_NUMBER, '0, '0,
                    nx.number_accum, nx.start_offset, nx.digit_count, 1'b0);
                n       = n + 1'b1;
                nx.mode = exlex_pkg::MODE_IDLE;
            end
            if (nx.mode != exlex_pkg::MODE_DISCARD) begin
                tok[n] = exlex_pkg::make_token(exlex_pkg::KIND_EOF, '0, '0, '0,
                    off_next, '0, 1'b1);
                n = n + 1'b1;
            end
            nx = exlex_pkg::reset_state();
        end else begin
            nx.byte_offset = off_next;
        end

        result.tok   = tok;
        result.count = n;
        result.state = nx;
    end

endmodule

`default_nettype wire

### rtl/exlex_fifo.sv
// Token queue that takes up to three tokens per cycle and gives one per cycle while the output is not stalled.
`default_nettype none

module exlex_fifo #(
    parameter int DEPTH = exlex_pkg::FIFO_DEPTH
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic [exlex_pkg::SLOT_CNT_W-1:0]       push_count,
    input  wire exlex_pkg::token_beat_t [exlex_pkg::TOK_SLOTS-1:0] push_tok,
    output logic                                        room,
    output logic [$clog2(DEPTH+1)-1:0]                  count,
    output logic                                        out_valid,
    input  wire logic                                   out_stall,
    output exlex_pkg::token_beat_t                      out_beat
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    exlex_pkg::token_beat_t mem_reg [DEPTH];
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             pop;

    assign pop       = out_valid && !out_stall;
    assign out_valid = (count_reg != '0);
    assign out_beat  = mem_reg[rd_ptr_reg];
    assign count     = count_reg;
    // Room for a full burst, without counting on a pop in the same cycle.
    assign room      = (count_reg <= CNT_W'(DEPTH - exlex_pkg::TOK_SLOTS));

    assign wr_ptr_next = wr_ptr_reg + PTR_W'(push_count);
    assign rd_ptr_next = rd_ptr_reg + PTR_W'(pop);
    assign count_next  = count_reg + CNT_W'(push_count) - CNT_W'(pop);

    always_ff @(posedge clk) begin
        for (int i = 0; i < exlex_pkg::TOK_SLOTS; i++) begin
            if (exlex_pkg::SLOT_CNT_W'(i) < push_count) begin
                mem_reg[wr_ptr_reg + PTR_W'(i)] <= push_tok[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

`default_nettype wire

### rtl/expression_lexer_core.sv
// Top level of the streaming expression lexer.
//
// The char channel (char_valid, char_stall, char_beat) carries one source byte
// per beat, with last_char set on the final byte of a string. The token channel
// (token_valid, token_stall, token_beat) carries one token per beat: operators,
// punctuators, one-letter identifiers, saturating decimal numbers, the closing
// end-of-input token and error tokens, each with its start offset and length.
// A beat accepted into the input register is lexed from there, and its tokens
// are pushed into the token queue once that has room for a full burst; one byte
// is taken every cycle while char_stall is low. A byte may close up to three
// tokens; the queue absorbs these bursts and char_stall rises only when fewer
// than three queue slots are free, which is what bounds the rate while the
// token side is slower than one token per cycle. Stalling the token side
// holds the head token steady and backs up into char_stall.
// Reset empties the queue and the input register and returns the lexer to the
// start of a string at offset zero.
`default_nettype none

module expression_lexer_core #(
    parameter int FIFO_DEPTH = exlex_pkg::FIFO_DEPTH
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 char_valid,
    output logic                      char_stall,
    input  wire exlex_pkg::char_beat_t char_beat,
    output logic                      token_valid,
    input  wire logic                 token_stall,
    output exlex_pkg::token_beat_t    token_beat
);

    // Input register: one byte waiting to be lexed.
    logic                  hold_valid_reg, hold_valid_next;
    exlex_pkg::char_beat_t hold_beat_reg;

    // Lexer state carried from byte to byte.
    exlex_pkg::lex_state_t state_reg, state_next;

    exlex_pkg::step_result_t             step;
    logic                                room;
    logic [$clog2(FIFO_DEPTH+1)-1:0]     queue_count;
    logic                                fire;
    logic                                accept;
    logic [exlex_pkg::SLOT_CNT_W-1:0]    push_count;

    // The held byte is lexed once the queue can take a full burst of tokens.
    assign fire       = hold_valid_reg && room;
    assign char_stall = hold_valid_reg && !room;
    assign accept     = char_valid && !char_stall;
    assign push_count = fire ? step.count : '0;

    assign hold_valid_next = accept || (hold_valid_reg && !fire);
    assign state_next      = fire ? step.state : state_reg;

    exlex_step u_step (
        .state  (state_reg),
        .beat   (hold_beat_reg),
        .result (step)
    );

    exlex_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_count (push_count),
        .push_tok   (step.tok),
        .room       (room),
        .count      (queue_count),
        .out_valid  (token_valid),
        .out_stall  (token_stall),
        .out_beat   (token_beat)
    );

    always_ff @(posedge clk) begin
        if (accept) begin
            hold_beat_reg <= char_beat;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            hold_valid_reg <= 1'b0;
            state_reg      <= exlex_pkg::reset_state();
        end else begin
            hold_valid_reg <= hold_valid_next;
            state_reg      <= state_next;
        end
    end

    // The queue never holds more tokens than it has slots.
    assert property (@(posedge clk) disable iff (!rst_n)
        queue_count <= ($clog2(FIFO_DEPTH+1))'(FIFO_DEPTH))
    else $error("token queue overfilled");

    // A byte in the middle of a discarded string produces no token.
    assert property (@(posedge clk) disable iff (!rst_n)
        fire && state_reg.mode == exlex_pkg::MODE_DISCARD && !hold_beat_reg.last_char
        |-> step.count == '0)
    else $error("token produced while discarding");

    // In a burst of two or more tokens, the first token may not close the string.
    assert property (@(posedge clk) disable iff (!rst_n)
        fire && step.count >= exlex_pkg::SLOT_CNT_W'(2) |-> !step.tok[0].final_token)
    else $error("closing token is not last in its burst");

    // After the final byte of a string the lexer is back at offset zero, idle.
    assert property (@(posedge clk) disable iff (!rst_n)
        fire && hold_beat_reg.last_char
        |=> state_reg.mode == exlex_pkg::MODE_IDLE && state_reg.byte_offset == '0)
    else $error("lexer not reset after end of string");

endmodule

`default_nettype wire

### sim/tb.sv
// Self-checking testbench for the streaming expression lexer core.
`timescale 1ns / 100ps

module tb;

    import exlex_pkg::*;

    // Run limits. The timeout is far above the slowest legal run: every byte
    // closing three tokens, each token waiting out the heaviest stall pattern,
    // plus one long hold-off.
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int RANDOM_TARGET = 380;
    localparam int HOLD_CYCLES   = 200;
    localparam int TAIL_CYCLES   = 16;

    localparam logic [LEN_W-1:0] NO_BYTES  = '0;
    localparam logic [LEN_W-1:0] ONE_BYTE  = 1;
    localparam logic [LEN_W-1:0] TWO_BYTES = 2;

    // One row of the directed script. Rows marked as typed carry the single
    // token they must produce; the other rows rely on the lexer predictor.
    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
        logic              typed;
        token_beat_t       tok;
    } script_row_t;

    logic        clk;
    logic        rst_n       = 1'b0;
    logic        char_valid  = 1'b0;
    logic        char_stall;
    char_beat_t  char_beat   = '0;
    logic        token_valid;
    logic        token_stall = 1'b0;
    token_beat_t token_beat;

    // Lexer state mirrored by the predictor.
    lex_mode_t         scan_mode;
    logic [CHAR_W-1:0] pend_char;
    logic [NUM_W-1:0]  num_value;
    logic [OFF_W-1:0]  pend_start;
    logic [LEN_W-1:0]  num_digits;
    logic [OFF_W-1:0]  next_offset;

    token_beat_t       step_tokens[$];
    token_beat_t       expected_tokens[$];
    script_row_t       script[$];
    logic [CHAR_W-1:0] text_buf[$];

    // The typed expectation that goes with the beat now on the char channel.
    bit          typed_now = 1'b0;
    token_beat_t typed_tok = '0;

    bit hold_request = 1'b0;
    int burst_left   = 0;
    int lexed_bytes  = 0;
    int failures     = 0;
    int cycle_count  = 0;

    expression_lexer_core dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .char_valid  (char_valid),
        .char_stall  (char_stall),
        .char_beat   (char_beat),
        .token_valid (token_valid),
        .token_stall (token_stall),
        .token_beat  (token_beat)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Lexer predictor
    // ------------------------------------------------------------------

    function automatic token_beat_t token_of(
        input logic [KIND_W-1:0] kind,
        input logic [CHAR_W-1:0] c1,
        input logic [CHAR_W-1:0] c2,
        input logic [NUM_W-1:0]  num,
        input logic [OFF_W-1:0]  start,
        input logic [LEN_W-1:0]  len,
        input logic              fin
    );
        token_beat_t t;
        t.token_kind   = kind;
        t.first_char   = c1;
        t.second_char  = c2;
        t.number_value = num;
        t.token_start  = start;
        t.token_length = len;
        t.final_token  = fin;
        return t;
    endfunction

    // Back to the start of a string at offset zero.
    function automatic void clear_lexer();
        scan_mode   = MODE_IDLE;
        pend_char   = '0;
        num_value   = '0;
        pend_start  = '0;
        num_digits  = '0;
        next_offset = '0;
    endfunction

    // A held '<' or '>' stands alone; a held '=' or '!' without a following
    // '=' is an error that kills the rest of the string.
    function automatic void settle_held();
        if (pend_char == CH_LT || pend_char == CH_GT)
        begin
            step_tokens.push_back(token_of(KIND_RESERVED, pend_char, '0, '0, pend_start,
                                           ONE_BYTE, 1'b0));
            scan_mode = MODE_IDLE;
        end
        else
        begin
            step_tokens.push_back(token_of(KIND_ERROR, '0, '0, '0, pend_start, ONE_BYTE, 1'b1));
            scan_mode = MODE_DISCARD;
        end
    endfunction

    function automatic void close_number();
        step_tokens.push_back(token_of(KIND_NUMBER, '0, '0, num_value, pend_start,
                                       num_digits, 1'b0));
        scan_mode = MODE_IDLE;
    endfunction

    // Works out the tokens that one accepted byte closes, in output order.
    function automatic void lex_byte(input logic [CHAR_W-1:0] c, input logic last);
        logic [OFF_W-1:0] off;
        bit               consumed;
        int unsigned      d;
        off      = next_offset;
        consumed = 1'b0;
        if (scan_mode != MODE_DISCARD)
            lexed_bytes++;

        // First let the pending operator or number react to this byte.
        case (scan_mode)
            MODE_DISCARD:
                consumed = 1'b1;
            MODE_HELD:
                if (c == CH_EQ)
                begin
                    step_tokens.push_back(token_of(KIND_RESERVED, pend_char, CH_EQ, '0,
                                                   pend_start, TWO_BYTES, 1'b0));
                    scan_mode = MODE_IDLE;
                    consumed  = 1'b1;
                end
                else
                begin
                    settle_held();
                    // After a lone '=' or '!' the next byte goes down with it.
                    consumed = (scan_mode == MODE_DISCARD);
                end
            MODE_NUMBER:
                if (c >= CH_ZERO && c <= CH_NINE)
                begin
                    d = c - CH_ZERO;
                    if (num_value > (NUM_MAX - d) / 10)
                        num_value = NUM_MAX;
                    else
                        num_value = num_value * 10 + d;
                    if (num_digits < MAX_TEXT_LEN)
                        num_digits++;
                    consumed = 1'b1;
                end
                else
                    close_number();
            default:
                ;
        endcase

        // Then start whatever this byte begins.
        if (!consumed)
        begin
            if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR))
                ;
            else if (c == CH_EQ || c == CH_BANG || c == CH_LT || c == CH_GT)
            begin
                pend_char  = c;
                pend_start = off;
                scan_mode  = MODE_HELD;
            end
            else if (c >= CH_LOW_A && c <= CH_LOW_Z)
                step_tokens.push_back(token_of(KIND_IDENT, c, '0, '0, off, ONE_BYTE, 1'b0));
            else if (c == CH_PLUS || c == CH_MINUS || c == CH_STAR || c == CH_SLASH ||
                     c == CH_LPAREN || c == CH_RPAREN || c == CH_LT || c == CH_GT ||
                     c == CH_SEMI)
                step_tokens.push_back(token_of(KIND_RESERVED, c, '0, '0, off, ONE_BYTE, 1'b0));
            else if (c >= CH_ZERO && c <= CH_NINE)
            begin
                num_value  = c - CH_ZERO;
                num_digits = ONE_BYTE;
                pend_start = off;
                scan_mode  = MODE_NUMBER;
            end
            else
            begin
                step_tokens.push_back(token_of(KIND_ERROR, '0, '0, '0, off, ONE_BYTE, 1'b1));
                scan_mode = MODE_DISCARD;
            end
        end

        // The last byte flushes what is pending and closes the string with an
        // end-of-input token, unless an error already closed it.
        if (last)
        begin
            if (scan_mode == MODE_HELD)
                settle_held();
            else if (scan_mode == MODE_NUMBER)
                close_number();
            if (scan_mode != MODE_DISCARD)
                step_tokens.push_back(token_of(KIND_EOF, '0, '0, '0, off + 1'b1,
                                               NO_BYTES, 1'b1));
            clear_lexer();
        end
        else
            next_offset = off + 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    function automatic void report_field(input string name, input logic [31:0] want,
                                         input logic [31:0] got);
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        failures++;
    endfunction

    function automatic void check_token(input token_beat_t got);
        token_beat_t want;
        if (expected_tokens.size() == 0)
        begin
            $display("%0t: unexpected token, kind %0d start %0d", $time,
                     got.token_kind, got.token_start);
            failures++;
            return;
        end
        want = expected_tokens.pop_front();
        if (got.token_kind !== want.token_kind)
            report_field("token_kind", want.token_kind, got.token_kind);
        if (got.first_char !== want.first_char)
            report_field("first_char", want.first_char, got.first_char);
        if (got.second_char !== want.second_char)
            report_field("second_char", want.second_char, got.second_char);
        if (got.number_value !== want.number_value)
            report_field("number_value", want.number_value, got.number_value);
        if (got.token_start !== want.token_start)
            report_field("token_start", want.token_start, got.token_start);
        if (got.token_length !== want.token_length)
            report_field("token_length", want.token_length, got.token_length);
        if (got.final_token !== want.final_token)
            report_field("final_token", want.final_token, got.final_token);
    endfunction

    // Both channels are watched from one block at the rising edge, so the
    // expectations of a byte are always queued before any later token beat is
    // compared. Inputs change only at the falling edge, so nothing sampled
    // here is in motion.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (char_valid && !char_stall)
            begin
                step_tokens.delete();
                lex_byte(char_beat.char_in, char_beat.last_char);
                if (typed_now)
                    expected_tokens.push_back(typed_tok);
                else
                    while (step_tokens.size() != 0)
                        expected_tokens.push_back(step_tokens.pop_front());
            end
            if (token_valid && !token_stall)
                check_token(token_beat);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Token side: stalls on patterns that change every so often, from none at
    // all to heavy, plus one long hold-off on request.
    // ------------------------------------------------------------------

    initial
    begin : token_sink
        int style;
        int style_left;
        style      = 0;
        style_left = 0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                // Hold the token side off long enough for the queue to fill and
                // for the char side to stall while bytes keep coming.
                hold_request = 1'b0;
                token_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            if (style_left == 0)
            begin
                style      = $urandom_range(0, 3);
                style_left = $urandom_range(16, 160);
            end
            style_left--;
            case (style)
                0:       token_stall <= 1'b0;
                1:       token_stall <= ($urandom_range(0, 3) == 0);
                2:       token_stall <= $urandom_range(0, 1);
                default: token_stall <= ($urandom_range(0, 4) != 0);
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Char side
    // ------------------------------------------------------------------

    // Offers one beat and returns at the falling edge after it was taken.
    // Beats go out in bursts of random length with random gaps in between;
    // a third of the bursts follow the previous one with no gap at all.
    task automatic send_byte(input logic [CHAR_W-1:0] c, input logic last,
                             input logic typed, input token_beat_t tok);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
            if (gap > 0)
            begin
                char_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        typed_now = typed;
        typed_tok = tok;
        char_valid          <= 1'b1;
        char_beat.char_in   <= c;
        char_beat.last_char <= last;
        @(posedge clk);
        while (char_stall)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Sends the string in text_buf, marking its final byte.
    task automatic send_text();
        for (int k = 0; k < text_buf.size(); k++)
            send_byte(text_buf[k], k == text_buf.size() - 1, 1'b0, '0);
    endtask

    // Stops offering beats until every expected token has come out.
    task automatic drain();
        char_valid <= 1'b0;
        while (expected_tokens.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    function automatic void add_row(input logic [CHAR_W-1:0] c, input logic last,
                                    input logic typed, input token_beat_t tok);
        script_row_t r;
        r.ch    = c;
        r.last  = last;
        r.typed = typed;
        r.tok   = tok;
        script.push_back(r);
    endfunction

    // Builds one random expression string: mostly well-formed tokens with
    // whitespace between some of them, now and then a stray byte or a lone
    // '=' or '!' that breaks the string.
    task automatic build_text();
        int    pieces;
        int    digits;
        string bound;
        text_buf.delete();
        pieces = $urandom_range(1, 10);
        repeat (pieces)
        begin
            case ($urandom_range(0, 23))
                0, 1, 2, 3:
                    text_buf.push_back(CH_LOW_A + 8'($urandom_range(0, 25)));
                4, 5, 6:
                    case ($urandom_range(0, 8))
                        0:       text_buf.push_back(CH_PLUS);
                        1:       text_buf.push_back(CH_MINUS);
                        2:       text_buf.push_back(CH_STAR);
                        3:       text_buf.push_back(CH_SLASH);
                        4:       text_buf.push_back(CH_LPAREN);
                        5:       text_buf.push_back(CH_RPAREN);
                        6:       text_buf.push_back(CH_LT);
                        7:       text_buf.push_back(CH_GT);
                        default: text_buf.push_back(CH_SEMI);
                    endcase
                7, 8:
                begin
                    case ($urandom_range(0, 3))
                        0:       text_buf.push_back(CH_EQ);
                        1:       text_buf.push_back(CH_BANG);
                        2:       text_buf.push_back(CH_LT);
                        default: text_buf.push_back(CH_GT);
                    endcase
                    text_buf.push_back(CH_EQ);
                end
                9:
                    text_buf.push_back($urandom_range(0, 1) ? CH_LT : CH_GT);
                10, 11, 12:
                begin
                    // Mostly short numbers; some long enough to saturate.
                    digits = ($urandom_range(0, 4) == 0) ? $urandom_range(9, 14)
                                                         : $urandom_range(1, 4);
                    repeat (digits)
                        text_buf.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
                end
                13:
                begin
                    // Right at and just past the saturation point.
                    bound = $urandom_range(0, 1) ? "2147483647" : "2147483648";
                    for (int i = 0; i < bound.len(); i++)
                        text_buf.push_back(bound[i]);
                end
                20:
                    text_buf.push_back(8'($urandom_range(0, 255)));
                21:
                    text_buf.push_back($urandom_range(0, 1) ? CH_EQ : CH_BANG);
                default:
                    repeat ($urandom_range(1, 3))
                        text_buf.push_back($urandom_range(0, 1) ? CH_SPACE
                                           : CH_TAB + 8'($urandom_range(0, 4)));
            endcase
        end
    endtask

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    initial
    begin : stimulus
        bit held_off;
        bit drained;
        held_off = 1'b0;
        drained  = 1'b0;
        clear_lexer();

        // String one walks the operators ==, !=, <, >=, + - * / and every punctuator,
        // and ends on a byte that closes a number, a lone '<' and the string itself.
        add_row(CH_LOW_A, 1'b0, 1'b1,
                token_of(KIND_IDENT, CH_LOW_A, '0, '0, 12'd0, ONE_BYTE, 1'b0));
        add_row(CH_LOW_Z, 1'b0, 1'b1,
                token_of(KIND_IDENT, CH_LOW_Z, '0, '0, 12'd1, ONE_BYTE, 1'b0));
        add_row(CH_EQ,   1'b0, 1'b0, '0);
        add_row(CH_EQ,   1'b0, 1'b0, '0);
        add_row(CH_BANG, 1'b0, 1'b0, '0);
        add_row(CH_EQ,   1'b0, 1'b0, '0);
        add_row(CH_LT,   1'b0, 1'b0, '0);
        add_row(CH_GT,   1'b0, 1'b0, '0);
        add_row(CH_EQ,   1'b0, 1'b0, '0);
        add_row(CH_PLUS, 1'b0, 1'b1,
                token_of(KIND_RESERVED, CH_PLUS, '0, '0, 12'd9, ONE_BYTE, 1'b0));
        add_row(CH_MINUS, 1'b0, 1'b1,
                token_of(KIND_RESERVED, CH_MINUS, '0, '0, 12'd10, ONE_BYTE, 1'b0));
        add_row(CH_STAR, 1'b0, 1'b1,
                token_of(KIND_RESERVED, CH_STAR, '0, '0, 12'd11, ONE_BYTE, 1'b0));
        add_row(CH_SLASH, 1'b0, 1'b1,
                token_of(KIND_RESERVED, CH_SLASH, '0, '0, 12'd12, ONE_BYTE, 1'b0));
        add_row(CH_LPAREN, 1'b0, 1'b1,
                token_of(KIND_RESERVED, CH_LPAREN, '0, '0, 12'd13, ONE_BYTE, 1'b0));
        add_row(CH_RPAREN, 1'b0, 1'b1,
                token_of(KIND_RESERVED, CH_RPAREN, '0, '0, 12'd14, ONE_BYTE, 1'b0));
        add_row(CH_SEMI, 1'b0, 1'b1,
                token_of(KIND_RESERVED, CH_SEMI, '0, '0, 12'd15, ONE_BYTE, 1'b0));
        add_row(CH_ZERO, 1'b0, 1'b0, '0);
        add_row(CH_NINE, 1'b0, 1'b0, '0);
        add_row(CH_LT,   1'b1, 1'b0, '0);
        // A lone '!' takes the byte after it down too; the top byte that ends
        // the string is ignored.
        add_row(CH_BANG, 1'b0, 1'b0, '0);
        add_row(CH_LOW_A + 8'd23, 1'b0, 1'b0, '0);
        add_row(8'hFF, 1'b1, 1'b0, '0);
        // A top byte alone is an error that also closes the string.
        add_row(8'hFF, 1'b1, 1'b1,
                token_of(KIND_ERROR, '0, '0, '0, 12'd0, ONE_BYTE, 1'b1));
        // NUL is an error; the whitespace after it is discarded.
        add_row(8'h00, 1'b0, 1'b1,
                token_of(KIND_ERROR, '0, '0, '0, 12'd0, ONE_BYTE, 1'b1));
        add_row(CH_SPACE, 1'b1, 1'b0, '0);
        // Whitespace only: just the end-of-input token, one past the byte.
        add_row(CH_SPACE, 1'b1, 1'b1,
                token_of(KIND_EOF, '0, '0, '0, 12'd1, NO_BYTES, 1'b1));
        // A lone '=' as the last byte is an error with no end token after it.
        add_row(CH_EQ, 1'b1, 1'b1,
                token_of(KIND_ERROR, '0, '0, '0, 12'd0, ONE_BYTE, 1'b1));

        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (script[i])
            send_byte(script[i].ch, script[i].last, script[i].typed, script[i].tok);
        drain();

        // Random strings. Part way in the token side is held off while bytes
        // keep coming, and later the char side waits for the queue to drain.
        while (lexed_bytes < RANDOM_TARGET)
        begin
            build_text();
            send_text();
            if (!held_off && lexed_bytes > 120)
            begin
                hold_request = 1'b1;
                held_off     = 1'b1;
            end
            if (!drained && lexed_bytes > 260)
            begin
                drain();
                drained = 1'b1;
            end
        end

        drain();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (failures == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

### expression_lexer_core.f
rtl/exlex_pkg.sv
rtl/exlex_step.sv
rtl/exlex_fifo.sv
rtl/expression_lexer_core.sv
sim/tb.sv
